FILE: hw/rtl/tst_pkg.sv
// Package for the timed suppression table: op and action codes, the
// controller state type and field widths. No dependencies.
`default_nettype none

package tst_pkg;

    // Default table depth
    localparam int SLOTS_DEFAULT = 16;

    // Field widths
    localparam int OWNER_W  = 16;
    localparam int PARAM_W  = 16;
    localparam int TIME_W   = 32;
    localparam int ENTRY_W  = OWNER_W + PARAM_W + TIME_W;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 8;

    // Op codes; code 3 is unused and ignored
    typedef enum logic [1:0] {
        OP_QUERY   = 2'd0,
        OP_REFRESH = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    // Refresh actions
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_UPDATE  = 3'd1,
        ACT_RECLAIM = 3'd2,
        ACT_APPEND  = 3'd3,
        ACT_EVICT   = 3'd4
    } action_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_RECLAIM,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/timed_suppression_table.sv
// Timed suppression table: slot memory, scan controller and output register.
// Depends on tst_pkg.
//
// The block holds up to SLOTS (owner, parameter, expiry) slots in one
// synchronous memory and takes one item at a time. A query or refresh scans
// the used slots at one memory read per cycle, and a refresh that finds no
// match runs a second scan for an expired slot. The output register is then
// loaded once it is free. Clear, the unused op and owner zero skip the scans;
// a refresh that appends or evicts runs both. A finished result waits in the
// output register while the next item is accepted; clear only resets the
// slot count, so no clearing pass runs after reset or clear.
`default_nettype none

module timed_suppression_table #(
    parameter int SLOTS = tst_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input item stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // owner_id[15:0], param_index[31:16], time_sample[63:32],
    // expiry_sample[95:64]
    input  wire logic [tst_pkg::S_DATA_W-1:0]  s_tdata,
    // op[1:0]
    input  wire logic [1:0]                    s_tuser,
    // result item stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // suppressed[0], refresh_action[3:1], slot_used[7:4]
    output logic [tst_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int OW    = tst_pkg::OWNER_W;
    localparam int PW    = tst_pkg::PARAM_W;
    localparam int TW    = tst_pkg::TIME_W;
    localparam int EW    = tst_pkg::ENTRY_W;

    // Slot memory: owner in low bits, then param, then expiry
    logic [EW-1:0] slot_mem [SLOTS];
    logic [EW-1:0] rd_data_reg;
    logic          rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic          wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    // Control registers
    tst_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Payload registers
    tst_pkg::op_t     op_reg, op_next;
    logic [OW-1:0]    owner_reg, owner_next;
    logic [PW-1:0]    param_reg, param_next;
    logic [TW-1:0]    now_reg, now_next;
    logic [TW-1:0]    expiry_reg, expiry_next;
    logic             res_supp_reg, res_supp_next;
    tst_pkg::action_t res_act_reg, res_act_next;
    logic [IDX_W-1:0] res_slot_reg, res_slot_next;
    logic [tst_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Slot fields of the word read last cycle
    logic [OW-1:0] rd_owner;
    logic [PW-1:0] rd_param;
    logic [TW-1:0] rd_expiry;
    logic [TW-1:0] live_diff;
    logic          rd_live;
    logic          key_match;
    logic          scan_more;
    logic          pass_end;
    logic          out_free;
    logic          in_accept;

    assign rd_owner  = rd_data_reg[OW-1:0];
    assign rd_param  = rd_data_reg[OW+PW-1:OW];
    assign rd_expiry = rd_data_reg[EW-1:OW+PW];
    assign live_diff = rd_expiry - now_reg;
    assign rd_live   = (live_diff != '0) && !live_diff[TW-1];
    assign key_match = (rd_owner == owner_reg) && (rd_param == param_reg);
    assign scan_more = (scan_idx_reg < count_reg);
    assign pass_end  = !chk_valid_reg && !scan_more;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign s_tready = (state_reg == tst_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Slot memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tst_pkg::ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        owner_reg    <= owner_next;
        param_reg    <= param_next;
        now_reg      <= now_next;
        expiry_reg   <= expiry_next;
        chk_idx_reg  <= chk_idx_next;
        res_supp_reg <= res_supp_next;
        res_act_reg  <= res_act_next;
        res_slot_reg <= res_slot_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Next state, memory accesses and results
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        m_tvalid_next  = m_tvalid_reg;
        op_next        = op_reg;
        owner_next     = owner_reg;
        param_next     = param_reg;
        now_next       = now_reg;
        expiry_next    = expiry_reg;
        res_supp_next  = res_supp_reg;
        res_act_next   = res_act_reg;
        res_slot_next  = res_slot_reg;
        m_tdata_next   = m_tdata_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = chk_idx_reg;
        wr_data        = {expiry_reg, param_reg, owner_reg};

        // Drop the result once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            tst_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next       = tst_pkg::op_t'(s_tuser);
                    owner_next    = s_tdata[OW-1:0];
                    param_next    = s_tdata[OW+PW-1:OW];
                    now_next      = s_tdata[OW+PW+TW-1:OW+PW];
                    expiry_next   = s_tdata[OW+PW+2*TW-1:OW+PW+TW];
                    scan_idx_next = '0;
                    res_supp_next = 1'b0;
                    res_act_next  = tst_pkg::ACT_NONE;
                    res_slot_next = '0;
                    state_next    = tst_pkg::ST_DONE;
                    case (tst_pkg::op_t'(s_tuser))
                        tst_pkg::OP_QUERY,
                        tst_pkg::OP_REFRESH:
                        begin
                            if (s_tdata[OW-1:0] != '0)
                            begin
                                state_next = tst_pkg::ST_MATCH;
                            end
                        end
                        tst_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = tst_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            tst_pkg::ST_MATCH:
            begin
                // Issue the next read while checking the previous one
                if (scan_more)
                begin
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end
                if (chk_valid_reg && key_match
                    && ((op_reg != tst_pkg::OP_QUERY) || rd_live))
                begin
                    chk_valid_next = 1'b0;
                    state_next     = tst_pkg::ST_DONE;
                    if (op_reg == tst_pkg::OP_QUERY)
                    begin
                        res_supp_next = 1'b1;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = chk_idx_reg;
                        res_act_next  = tst_pkg::ACT_UPDATE;
                        res_slot_next = chk_idx_reg;
                    end
                end
                else if (pass_end)
                begin
                    if (op_reg == tst_pkg::OP_QUERY)
                    begin
                        state_next = tst_pkg::ST_DONE;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        state_next    = tst_pkg::ST_RECLAIM;
                    end
                end
            end

            tst_pkg::ST_RECLAIM:
            begin
                // Look for the first expired slot; if none, append or evict slot 0
                if (scan_more)
                begin
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end
                if (chk_valid_reg && !rd_live)
                begin
                    chk_valid_next = 1'b0;
                    wr_en          = 1'b1;
                    wr_addr        = chk_idx_reg;
                    res_act_next   = tst_pkg::ACT_RECLAIM;
                    res_slot_next  = chk_idx_reg;
                    state_next     = tst_pkg::ST_DONE;
                end
                else if (pass_end)
                begin
                    wr_en      = 1'b1;
                    state_next = tst_pkg::ST_DONE;
                    if (count_reg < CNT_W'(SLOTS))
                    begin
                        wr_addr       = count_reg[IDX_W-1:0];
                        count_next    = count_reg + CNT_W'(1);
                        res_act_next  = tst_pkg::ACT_APPEND;
                        res_slot_next = count_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        wr_addr       = '0;
                        res_act_next  = tst_pkg::ACT_EVICT;
                        res_slot_next = '0;
                    end
                end
            end

            tst_pkg::ST_DONE:
            begin
                // Load the output register when it is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'(res_slot_reg), res_act_reg, res_supp_reg};
                    state_next    = tst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tst_pkg::ST_IDLE;
            end
        endcase
    end

    // Slot count never exceeds the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
    else $error("slot count above table depth");

    // Memory writes happen only during a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == tst_pkg::ST_MATCH || state_reg == tst_pkg::ST_RECLAIM))
    else $error("slot write outside a scan");

    // Reads stay within the used slots
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (scan_idx_reg < count_reg))
    else $error("slot read beyond used slots");

    // A clear empties the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tuser == tst_pkg::OP_CLEAR) |=> (count_reg == '0))
    else $error("clear left slots in use");

    // A result is loaded only when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tst_pkg::ST_DONE && m_tvalid_reg && !m_tready) |=> m_tvalid_reg)
    else $error("stalled result lost");

endmodule

`default_nettype wire
